FILE: rtl/pla_pkg.sv
// Package for the polyline length accumulator: field widths, derived sizes
// and the command bundle passed from the sequencer to the accumulators.
// No dependencies.
package pla_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int ACC_W   = 48;

  // Squares and their sum; the root walks the sum two bits at a time
  localparam int SQ_W       = 2 * COORD_W;
  localparam int RAD_W      = SQ_W + 1;
  localparam int ROOT_PAIRS = (RAD_W + 1) / 2;
  localparam int ROOT_W     = ROOT_PAIRS;
  localparam int RAD_PAD_W  = 2 * ROOT_PAIRS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CNT_W      = $clog2(ROOT_PAIRS + 1);

  // Stream bus widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * ACC_W + 7) / 8) * 8;

  // Accumulator commands
  typedef struct packed {
    logic clr_chain;  // drop the open chain
    logic add_seg;    // add one segment length to the chain
    logic close;      // fold chain into total and restart the chain
    logic last;       // with close: clear the total afterwards
  } pla_acc_cmd_t;

endpackage

FILE: rtl/polyline_length_accumulator.sv
// Polyline length accumulator, built on pla_pkg, pla_isqrt and pla_acc.
// A point that continues a chain passes accept, two squarings on one 24x24
// multiplier, a root start, a 25-step bit-pair square root and a done cycle
// that accumulates; a chain end adds a close state. An opening point needs
// only accept, and close if it also ends the chain. One point is in work at
// a time; a result waits in the output register. Synchronous active-low reset.
module polyline_length_accumulator import pla_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input points
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // x_coord, y_coord
  input  logic [1:0]             in_tuser,   // chain_start, set_end
  input  logic                   in_tlast,   // chain_end
  // Results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // chain_length, total_length
  output logic                   out_tlast   // is_final
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_LOAD,
    S_ROOT,
    S_CLOSE
  } state_t;

  state_t               state_r, state_nxt;
  logic [COORD_W-1:0]   prev_x_r, prev_x_nxt;
  logic [COORD_W-1:0]   prev_y_r, prev_y_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [COORD_W-1:0]   dx_r, dx_nxt;
  logic [COORD_W-1:0]   dy_r, dy_nxt;
  logic                 end_r, end_nxt;
  logic                 last_r, last_nxt;
  logic [SQ_W-1:0]      prod_r, prod_nxt;
  logic [SQ_W-1:0]      rad_r, rad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]     out_chain_r, out_chain_nxt;
  logic [ACC_W-1:0]     out_total_r, out_total_nxt;
  logic                 out_final_r, out_final_nxt;

  logic [COORD_W-1:0]   in_x, in_y;
  logic                 in_start, in_set_end;
  logic                 accept;
  logic                 slot_free;
  logic [COORD_W:0]     diff_x, diff_y;
  logic [COORD_W-1:0]   mult_a;
  logic                 sq_start;
  logic [RAD_W-1:0]     sq_rad;
  logic                 sq_done;
  logic [ROOT_W-1:0]    sq_root;
  pla_acc_cmd_t         acc_cmd;
  logic [ACC_W-1:0]     chain_len, total_len;

  // Unpack the request
  assign in_x       = in_tdata[COORD_W-1:0];
  assign in_y       = in_tdata[2*COORD_W-1:COORD_W];
  assign in_start   = in_tuser[0];
  assign in_set_end = in_tuser[1];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Signed differences against the previous point, one bit wider
  assign diff_x = {in_x[COORD_W-1], in_x} - {prev_x_r[COORD_W-1], prev_x_r};
  assign diff_y = {in_y[COORD_W-1], in_y} - {prev_y_r[COORD_W-1], prev_y_r};

  // Shared squarer operand
  assign mult_a = (state_r == S_SQX) ? dx_r : dy_r;

  // Sum of squares feeds the root unit
  assign sq_rad   = {1'b0, rad_r} + {1'b0, prod_r};
  assign sq_start = (state_r == S_LOAD);

  pla_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  pla_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (acc_cmd),
    .seg       (sq_root),
    .chain_len (chain_len),
    .total_len (total_len)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    rad_nxt       = rad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_chain_nxt = out_chain_r;
    out_total_nxt = out_total_r;
    out_final_nxt = out_final_r;
    acc_cmd       = '0;
    acc_cmd.last  = last_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          dx_nxt        = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
          dy_nxt        = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
          end_nxt       = in_tlast;
          last_nxt      = in_set_end;
          prev_x_nxt    = in_x;
          prev_y_nxt    = in_y;
          have_prev_nxt = !in_tlast;
          if (in_start || !have_prev_r) begin
            // Opening point: no segment to measure
            acc_cmd.clr_chain = 1'b1;
            state_nxt         = in_tlast ? S_CLOSE : S_IDLE;
          end else begin
            state_nxt = S_SQX;
          end
        end
      end
      S_SQX: begin
        prod_nxt  = mult_a * mult_a;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        rad_nxt   = prod_r;
        prod_nxt  = mult_a * mult_a;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sq_done) begin
          acc_cmd.add_seg = 1'b1;
          state_nxt       = end_r ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (slot_free) begin
          acc_cmd.close = 1'b1;
          out_valid_nxt = 1'b1;
          out_chain_nxt = chain_len;
          out_total_nxt = total_len;
          out_final_nxt = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    end_r       <= end_nxt;
    last_r      <= last_nxt;
    prod_r      <= prod_nxt;
    rad_r       <= rad_nxt;
    out_chain_r <= out_chain_nxt;
    out_total_r <= out_total_nxt;
    out_final_r <= out_final_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_total_r, out_chain_r});
  assign out_tlast  = out_final_r;

endmodule

FILE: rtl/pla_isqrt.sv
// Digit-serial integer square root: one radicand bit pair per cycle.
// Depends on pla_pkg.
module pla_isqrt import pla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_PAD_W-1:0] rad_sr_r, rad_sr_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;

  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic [REM_W+1:0]     rem_sub;

  // One restoring step: bring in the next pair, try 4*root+1
  assign rem_sh  = {rem_r, rad_sr_r[RAD_PAD_W-1 -: 2]};
  assign trial   = (REM_W+2)'({root_r, 2'b01});
  assign rem_sub = rem_sh - trial;

  always_comb begin
    rad_sr_nxt = rad_sr_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    if (start) begin
      rad_sr_nxt = RAD_PAD_W'(rad);
      rem_nxt    = '0;
      root_nxt   = '0;
      cnt_nxt    = CNT_W'(ROOT_PAIRS);
      run_nxt    = 1'b1;
    end else if (run_r) begin
      rad_sr_nxt = {rad_sr_r[RAD_PAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sub[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_sr_r <= rad_sr_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    cnt_r    <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/pla_acc.sv
// Saturating chain and set accumulators.
// Depends on pla_pkg.
module pla_acc import pla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pla_acc_cmd_t      cmd,
  input  logic [ROOT_W-1:0] seg,
  output logic [ACC_W-1:0]  chain_len,
  output logic [ACC_W-1:0]  total_len
);

  logic [ACC_W-1:0] chain_r, chain_nxt;
  logic [ACC_W-1:0] grand_r, grand_nxt;
  logic [ACC_W-1:0] chain_add;
  logic [ACC_W-1:0] grand_add;

  // Add that sticks at all ones on carry out
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  assign chain_add = sat_add(chain_r, ACC_W'(seg));
  assign grand_add = sat_add(grand_r, chain_r);

  always_comb begin
    chain_nxt = chain_r;
    grand_nxt = grand_r;
    if (cmd.close) begin
      chain_nxt = '0;
      grand_nxt = cmd.last ? '0 : grand_add;
    end else if (cmd.clr_chain) begin
      chain_nxt = '0;
    end else if (cmd.add_seg) begin
      chain_nxt = chain_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
      grand_r <= '0;
    end else begin
      chain_r <= chain_nxt;
      grand_r <= grand_nxt;
    end
  end

  assign chain_len = chain_r;
  assign total_len = grand_add;

endmodule

FILE: test/tb_polyline_length_accumulator.sv
// Testbench for polyline_length_accumulator: streams 2-D points, predicts each
// chain result with a local length model and checks every result field.
// Depends on pla_pkg and the polyline_length_accumulator RTL.
`timescale 1ns / 100ps

module tb_polyline_length_accumulator;
  import pla_pkg::*;

  typedef struct {
    logic [ACC_W-1:0] chain_len;
    logic [ACC_W-1:0] total_len;
    logic             closes_set;
  } chain_result_t;

  localparam logic [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam int                 DRAIN_WAIT = 64;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // x_coord, y_coord
  logic [1:0]             in_tuser = '0;   // chain_start, set_end
  logic                   in_tlast = 1'b0; // chain_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // chain_length, total_length
  logic                   out_tlast;       // is_final

  // Length model state
  logic [COORD_W-1:0] last_x, last_y;
  logic [ACC_W-1:0]   open_chain_len, set_total_len;
  logic               chain_open;

  chain_result_t pending_chains[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int stall_request = 0;
  logic holding_off = 1'b0;
  int points_sent = 0;
  int chains_checked = 0;
  int mismatch_count = 0;

  polyline_length_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Length model
  // ---------------------------------------------------------------------------

  // Largest r with r*r <= rad, set one bit at a time from the top
  function automatic logic [31:0] floor_root(logic [63:0] rad);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= rad) root = trial;
    end
    return root;
  endfunction

  function automatic logic [ACC_W-1:0] point_distance(
      logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
      logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
    logic signed [COORD_W:0] dx, dy;
    logic [63:0] ax, ay;
    dx = $signed({x1[COORD_W-1], x1}) - $signed({x0[COORD_W-1], x0});
    dy = $signed({y1[COORD_W-1], y1}) - $signed({y0[COORD_W-1], y0});
    ax = (dx < 0) ? 64'(-dx) : 64'(dx);
    ay = (dy < 0) ? 64'(-dy) : 64'(dy);
    return ACC_W'(floor_root(ax * ax + ay * ay));
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  // Advance the model by one accepted point; queue the chain result if it closes
  task automatic predict_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic start, logic chain_end, logic set_end);
    chain_result_t r;
    if (start || !chain_open) open_chain_len = '0;
    else open_chain_len = sat_add(open_chain_len, point_distance(last_x, last_y, x, y));
    last_x = x;
    last_y = y;
    chain_open = 1'b1;
    if (chain_end) begin
      set_total_len = sat_add(set_total_len, open_chain_len);
      r.chain_len = open_chain_len;
      r.total_len = set_total_len;
      r.closes_set = set_end;
      pending_chains.push_back(r);
      open_chain_len = '0;
      chain_open = 1'b0;
      if (set_end) set_total_len = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one point, after a random idle gap, and wait for the request to be taken
  task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic start, logic chain_end, logic set_end);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= {set_end, start};
    in_tlast  <= chain_end;
    do @(posedge clk); while (!in_tready);
    predict_point(x, y, start, chain_end, set_end);
    points_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
    mismatch_count++;
    $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_chain_result();
    chain_result_t want;
    if (pending_chains.size() == 0) begin
      report_mismatch("result with no chain pending", out_tdata[ACC_W-1:0], '0);
    end else begin
      want = pending_chains.pop_front();
      chains_checked++;
      if (out_tdata[ACC_W-1:0] !== want.chain_len)
        report_mismatch("chain_length", out_tdata[ACC_W-1:0], want.chain_len);
      if (out_tdata[2*ACC_W-1:ACC_W] !== want.total_len)
        report_mismatch("total_length", out_tdata[2*ACC_W-1:ACC_W], want.total_len);
      if (out_tlast !== want.closes_set)
        report_mismatch("is_final", ACC_W'(out_tlast), ACC_W'(want.closes_set));
    end
  endtask

  // Long receiver hold-off, counted in cycles
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        holding_off <= 1'b1;
        repeat (stall_request) @(posedge clk);
        holding_off <= 1'b0;
        stall_request = 0;
      end
    end
  end

  // Check each accepted result; drive ready with random stalls or the hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_chain_result();
    if (holding_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0, 1:    return COORD_W'($urandom);
      2:       case ($urandom_range(3))
                 0: return COORD_MAX;
                 1: return COORD_MIN;
                 2: return '0;
                 default: return '1;
               endcase
      default: return COORD_W'($signed($urandom_range(8191)) - 4096);
    endcase
  endfunction

  // Next point of a chain: mostly a short step, sometimes a long jump
  function automatic logic [COORD_W-1:0] step_coord(logic [COORD_W-1:0] from);
    case ($urandom_range(7))
      0:       return rand_coord();
      1:       return from;
      2:       return from + COORD_W'($signed($urandom_range(131071)) - 65536);
      default: return from + COORD_W'($signed($urandom_range(511)) - 256);
    endcase
  endfunction

  // Well-formed chains with random content, plus some stray points
  task automatic send_chains(int n_points);
    int target, len;
    logic [COORD_W-1:0] x, y;
    target = points_sent + n_points;
    while (points_sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_point(rand_coord(), rand_coord(), 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        len = $urandom_range(1, 8);
        x = rand_coord();
        y = rand_coord();
        for (int i = 0; i < len; i++) begin
          if (i > 0) begin
            x = step_coord(x);
            y = step_coord(y);
          end
          send_point(x, y, (i == 0) ? ($urandom_range(4) != 0) : 1'b0,
                     i == len - 1,
                     (i == len - 1) ? ($urandom_range(3) == 0) : 1'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    // Start and end on one point
    send_point('0, '0, 1'b1, 1'b1, 1'b0);
    // Longest segment: corner to corner
    send_point(COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1, 1'b0);
    // Point with no open chain starts one; 3-4-5 triangle
    send_point(24'd100, 24'd200, 1'b0, 1'b0, 1'b0);
    send_point(24'd868, 24'd1224, 1'b0, 1'b1, 1'b0);
    // Set end without chain end is ignored; then close the set
    send_point('0, '0, 1'b1, 1'b0, 1'b1);
    send_point(24'd256, '0, 1'b0, 1'b0, 1'b0);
    send_point(24'd256, 24'd256, 1'b0, 1'b1, 1'b1);
    // Total restarts after the set end
    send_point('0, '0, 1'b1, 1'b0, 1'b0);
    send_point(-24'sd256, '0, 1'b0, 1'b1, 1'b0);
    // Start inside an open chain drops the open length
    send_point('0, '0, 1'b1, 1'b0, 1'b0);
    send_point(24'd1000, '0, 1'b0, 1'b0, 1'b0);
    send_point(24'd5, 24'd5, 1'b1, 1'b0, 1'b0);
    send_point(24'd5, 24'd305, 1'b0, 1'b1, 1'b0);
    // Repeated point adds nothing
    send_point(24'd77, 24'd77, 1'b1, 1'b0, 1'b0);
    send_point(24'd77, 24'd77, 1'b0, 1'b1, 1'b0);
    // Full swing on x, then on y
    send_point(COORD_MAX, '0, 1'b1, 1'b0, 1'b0);
    send_point(COORD_MIN, '0, 1'b0, 1'b1, 1'b1);
    send_point('0, COORD_MAX, 1'b1, 1'b0, 1'b0);
    send_point('0, COORD_MIN, 1'b0, 1'b0, 1'b0);
    send_point('1, '1, 1'b0, 1'b0, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_random_phase(int idle, int stall, int n_points);
    send_idle_pct = idle;
    stall_pct = stall;
    send_chains(n_points);
  endtask

  // Receiver holds off for a long stretch while points keep coming
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    stall_pct = 0;
    stall_request = 600;
    for (int i = 0; i < 40; i++)
      send_point(rand_coord(), rand_coord(), i % 4 == 0, i % 2 == 1, i % 8 == 7);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_chains.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    last_x = '0;
    last_y = '0;
    open_chain_len = '0;
    set_total_len = '0;
    chain_open = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phase(0, 0, 440);
    test_random_phase(87, 0, 440);
    test_random_phase(0, 87, 440);
    test_output_hold_off();
    test_random_phase(24, 24, 440);
    wait_for_drain();

    if (pending_chains.size() != 0)
      report_mismatch("chain results never seen", ACC_W'(pending_chains.size()), '0);
    $display("Sent %0d points over four idle/stall phases and one long output hold-off;",
             points_sent);
    $display("checked %0d chain results, %0d mismatches.", chains_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pla_pkg.sv
rtl/pla_isqrt.sv
rtl/pla_acc.sv
rtl/polyline_length_accumulator.sv
test/tb_polyline_length_accumulator.sv
